FILE: rtl/core/gcss_pkg.sv
// ----------------------------------------------------------------------------
// gcss_pkg
// Shared types, constants and helpers for the Gray-code subset-sum search.
// ----------------------------------------------------------------------------
package gcss_pkg;

  localparam int unsigned MaxItems  = 16;
  localparam int unsigned SizeBits  = 24;
  localparam int unsigned AddrBits  = $clog2(MaxItems);
  localparam int unsigned CountBits = $clog2(MaxItems + 1);
  localparam int unsigned StepBits  = MaxItems + 1;
  localparam int unsigned SumBits   = SizeBits + AddrBits;

  // Capacity after reset: 4.3 MiB scaled by 0.99
  localparam logic [SizeBits-1:0] CapReset = SizeBits'(4463788);

  typedef logic [SizeBits-1:0] size_t;
  typedef logic [MaxItems-1:0] mask_t;
  typedef logic [AddrBits-1:0] addr_t;

  // Input beat
  typedef struct packed {
    size_t item_size;
    logic  last_item;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    size_t best_total;
    mask_t best_set;
    logic  overflow;
  } out_beat_t;

  // Index of the lowest set bit; zero input gives index 0
  function automatic addr_t low_bit_idx(mask_t v);
    addr_t idx;
    idx = '0;
    for (int i = MaxItems - 1; i >= 0; i--) begin
      if (v[i]) idx = AddrBits'(i);
    end
    return idx;
  endfunction

endpackage

FILE: rtl/core/gcss_size_ram.sv
// ----------------------------------------------------------------------------
// gcss_size_ram
// Item size store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gcss_size_ram (
  input  logic            clk_i,
  input  logic            we_i,
  input  gcss_pkg::addr_t waddr_i,
  input  gcss_pkg::size_t wdata_i,
  input  gcss_pkg::addr_t raddr_i,
  output gcss_pkg::size_t rdata_o
);

  gcss_pkg::size_t mem [gcss_pkg::MaxItems];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/core/gray_code_subset_sum_search.sv
// ----------------------------------------------------------------------------
// gray_code_subset_sum_search
// Exhaustive subset-sum search over up to 16 item sizes in Gray-code order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/ready) carries one item size per beat; a beat with
//   last_item set closes the set and starts the search. Sizes beyond 16 are
//   dropped and the result's overflow bit is set.
//   Output channel (valid/ready) carries one result beat per set: the
//   largest subset sum strictly below capacity and the mask of its items.
//   cfg_we_i/cfg_wdata_i write the capacity register; write only when idle.
// Timing:
//   Items load one per accepted beat. After the last item, the search walks
//   2^N - 1 steps at one step per cycle (N stored items), one read of the
//   size store each, then passes a drain state for the registered read and
//   a done state that posts the result.
//   The size store's single read port sets the pace, one item per step.
// Reset:
//   Clears item count, search state and the best-so-far registers; capacity
//   returns to its reset value. The size store is not cleared.
// Stall:
//   The result sits in an output register, so the next set can load while
//   it waits. A search that finishes with the register still full holds
//   until the receiver takes the pending beat.
// ----------------------------------------------------------------------------
module gray_code_subset_sum_search (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gcss_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gcss_pkg::out_beat_t out_data_o,
  input  logic                cfg_we_i,
  input  gcss_pkg::size_t     cfg_wdata_i
);

  typedef enum logic [1:0] {
    StLoad,
    StSearch,
    StDrain,
    StDone
  } state_e;

  typedef logic [gcss_pkg::CountBits-1:0] count_t;
  typedef logic [gcss_pkg::StepBits-1:0]  step_t;
  typedef logic [gcss_pkg::SumBits-1:0]   sum_t;

  state_e              state_q, state_d;
  gcss_pkg::size_t     cap_q, cap_d;
  count_t              count_q, count_d;
  logic                ovf_q, ovf_d;
  step_t               step_q, step_d;
  step_t               last_step_q, last_step_d;
  sum_t                sum_q, sum_d;
  gcss_pkg::size_t     best_q, best_d;
  gcss_pkg::mask_t     best_mask_q, best_mask_d;
  logic                pv_q, pv_d;
  logic                padd_q, padd_d;
  gcss_pkg::mask_t     pgray_q, pgray_d;
  logic                out_valid_q, out_valid_d;
  gcss_pkg::out_beat_t out_q, out_d;

  logic                in_fire;
  logic                ram_we;
  gcss_pkg::addr_t     rd_addr;
  gcss_pkg::size_t     rd_data;
  gcss_pkg::mask_t     step_lo;
  gcss_pkg::mask_t     gray_now;
  sum_t                sum_next;
  count_t              count_new;

  assign in_ready_o  = (state_q == StLoad);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Store writes only while room remains
  assign ram_we = in_fire && (count_q < count_t'(gcss_pkg::MaxItems));

  // Step address: changed Gray bit is the lowest set bit of the counter
  assign step_lo  = step_q[gcss_pkg::MaxItems-1:0];
  assign gray_now = step_lo ^ (step_lo >> 1);
  assign rd_addr  = gcss_pkg::low_bit_idx(step_lo);

  gcss_size_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[gcss_pkg::AddrBits-1:0]),
    .wdata_i (in_data_i.item_size),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Running sum update from the read data of the previous step
  assign sum_next = padd_q ? sum_q + sum_t'(rd_data) : sum_q - sum_t'(rd_data);
  assign count_new = ram_we ? count_q + count_t'(1) : count_q;

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    cap_d       = cfg_we_i ? cfg_wdata_i : cap_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    step_d      = step_q;
    last_step_d = last_step_q;
    sum_d       = sum_q;
    best_d      = best_q;
    best_mask_d = best_mask_q;
    pv_d        = 1'b0;
    padd_d      = padd_q;
    pgray_d     = pgray_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    // Evaluate the step whose size just came out of the store
    if (pv_q) begin
      sum_d = sum_next;
      if ((sum_next < sum_t'(cap_q)) && (sum_next > sum_t'(best_q))) begin
        best_d      = gcss_pkg::size_t'(sum_next);
        best_mask_d = pgray_q;
      end
    end

    unique case (state_q)
      StLoad: begin
        if (in_fire) begin
          count_d = count_new;
          if (!ram_we) ovf_d = 1'b1;
          if (in_data_i.last_item) begin
            state_d     = StSearch;
            step_d      = step_t'(1);
            last_step_d = (step_t'(1) << count_new) - step_t'(1);
            sum_d       = '0;
            best_d      = '0;
            best_mask_d = '0;
          end
        end
      end
      StSearch: begin
        pv_d    = 1'b1;
        padd_d  = gray_now[rd_addr];
        pgray_d = gray_now;
        step_d  = step_q + step_t'(1);
        if (step_q == last_step_q) state_d = StDrain;
      end
      StDrain: begin
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d      = 1'b1;
          out_d.best_total = best_q;
          out_d.best_set   = best_mask_q;
          out_d.overflow   = ovf_q;
          count_d          = '0;
          ovf_d            = 1'b0;
          sum_d            = '0;
          step_d           = '0;
          state_d          = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      cap_q       <= gcss_pkg::CapReset;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      step_q      <= '0;
      last_step_q <= '0;
      sum_q       <= '0;
      best_q      <= '0;
      best_mask_q <= '0;
      pv_q        <= 1'b0;
      padd_q      <= 1'b0;
      pgray_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      step_q      <= step_d;
      last_step_q <= last_step_d;
      sum_q       <= sum_d;
      best_q      <= best_d;
      best_mask_q <= best_mask_d;
      pv_q        <= pv_d;
      padd_q      <= padd_d;
      pgray_q     <= pgray_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule
